>>> src/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the polygon fan triangulator
// Fixed position width, fan size and the result slot codes.
// ----------------------------------------------------------------------------
package pft_pkg;

	// Stream position counter width; wraps at 2^POS_BITS
	localparam int unsigned POS_BITS = 24;

	// Corner count above which a polygon starts emitting full triangles
	localparam logic [1:0] FAN_CORNERS = 2'd2;
	localparam logic [1:0] CORNER_MAX  = 2'd3;

	// Which corner of the held item is on the output
	typedef enum logic [1:0] {
		SLOT_FAN  = 2'd0,
		SLOT_PREV = 2'd1,
		SLOT_CUR  = 2'd2
	} slot_t;

endpackage

>>> src/polygon_fan_triangulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_triangulator: fan triangulation of a polygon index stream
// Decodes vertex indices, tracks the fan and streams out triangle corners.
// ----------------------------------------------------------------------------
// Takes one polygon vertex index per input transaction; a negative index closes
// the polygon and is decoded as its bitwise complement. The first three
// vertices of a polygon come out as one result each; every later vertex comes
// out as three results (fan vertex, previous vertex, current vertex), with
// last set on the final result of the item. All polygon bookkeeping is done in
// the cycle of acceptance and the item's corners are parked in one holding
// stage that feeds the single result port. An item with one result therefore
// holds the port for one corner and an item with three results for three
// corners: the output port, one corner per cycle while out_ready is high, sets
// the rate. A new item is taken in the same cycle in which the held item's last
// corner is taken, so no bubble is inserted between items. start_of_mesh clears
// the stream position and the polygon state before its own item. The first
// result of an item is on the output in the cycle after its acceptance.
module polygon_fan_triangulator #(
	parameter int unsigned INDEX_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [INDEX_BITS:0]    raw_index,
	input  logic                          start_of_mesh,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [INDEX_BITS-1:0]         vertex_index,
	output logic [pft_pkg::POS_BITS-1:0]  source_position,
	output logic                          last
);
	import pft_pkg::*;

	// polygon state
	logic [1:0]            corner_q;
	logic [INDEX_BITS-1:0] fan_vert_q;
	logic [POS_BITS-1:0]   fan_pos_q;
	logic [INDEX_BITS-1:0] prev_vert_q;
	logic [POS_BITS-1:0]   prev_pos_q;
	logic [POS_BITS-1:0]   stream_q;

	// holding stage: the corners of one accepted item
	logic                  valid_s1;
	logic                  three_s1;
	slot_t                 slot_s1;
	logic [INDEX_BITS-1:0] fan_vert_s1;
	logic [POS_BITS-1:0]   fan_pos_s1;
	logic [INDEX_BITS-1:0] prev_vert_s1;
	logic [POS_BITS-1:0]   prev_pos_s1;
	logic [INDEX_BITS-1:0] cur_vert_s1;
	logic [POS_BITS-1:0]   cur_pos_s1;

	// decode and current-item view of the state
	logic                  in_fire;
	logic                  out_fire;
	logic                  ends;
	logic [INDEX_BITS-1:0] vert;
	logic [1:0]            corner_cur;
	logic [POS_BITS-1:0]   pos_cur;
	logic                  three_cur;
	slot_t                 slot_next;

	assign ends       = raw_index[INDEX_BITS];
	assign vert       = ends ? ~raw_index[INDEX_BITS-1:0] : raw_index[INDEX_BITS-1:0];
	assign corner_cur = start_of_mesh ? 2'd0 : corner_q;
	assign pos_cur    = start_of_mesh ? '0 : stream_q;
	assign three_cur  = (corner_cur > FAN_CORNERS);

	// a held item ends on its current-vertex corner
	assign last      = (slot_s1 == SLOT_CUR);
	assign out_valid = valid_s1;
	assign out_fire  = out_valid && out_ready;
	// take a new item when the stage is empty or drains this cycle
	assign in_ready  = !valid_s1 || (out_ready && last);
	assign in_fire   = in_valid && in_ready;

	// corner selection for the output port
	always_comb begin
		unique case (slot_s1)
			SLOT_FAN: begin
				vertex_index    = fan_vert_s1;
				source_position = fan_pos_s1;
				slot_next       = SLOT_PREV;
			end
			SLOT_PREV: begin
				vertex_index    = prev_vert_s1;
				source_position = prev_pos_s1;
				slot_next       = SLOT_CUR;
			end
			SLOT_CUR: begin
				vertex_index    = cur_vert_s1;
				source_position = cur_pos_s1;
				slot_next       = SLOT_CUR;
			end
			default: begin
				vertex_index    = cur_vert_s1;
				source_position = cur_pos_s1;
				slot_next       = SLOT_CUR;
			end
		endcase
	end

	// polygon state: update on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q    <= '0;
			stream_q    <= '0;
			fan_vert_q  <= '0;
			fan_pos_q   <= '0;
			prev_vert_q <= '0;
			prev_pos_q  <= '0;
		end else if (in_fire) begin
			if (corner_cur == 2'd0) begin
				fan_vert_q <= vert;
				fan_pos_q  <= pos_cur;
			end
			prev_vert_q <= vert;
			prev_pos_q  <= pos_cur;
			// close the polygon or count the corner, saturating
			if (ends) begin
				corner_q <= '0;
			end else if (corner_cur < CORNER_MAX) begin
				corner_q <= corner_cur + 2'd1;
			end else begin
				corner_q <= corner_cur;
			end
			stream_q <= pos_cur + POS_BITS'(1);
		end
	end

	// holding stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			three_s1 <= 1'b0;
			slot_s1  <= SLOT_CUR;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			three_s1 <= three_cur;
			// a single-corner item goes straight to its own corner
			slot_s1  <= three_cur ? SLOT_FAN : SLOT_CUR;
		end else if (out_fire) begin
			if (last) begin
				valid_s1 <= 1'b0;
			end else begin
				slot_s1 <= slot_next;
			end
		end
	end

	// holding stage payload: snapshot of the fan before this item's update
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fan_vert_s1  <= fan_vert_q;
			fan_pos_s1   <= fan_pos_q;
			prev_vert_s1 <= prev_vert_q;
			prev_pos_s1  <= prev_pos_q;
			cur_vert_s1  <= vert;
			cur_pos_s1   <= pos_cur;
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_single_on_cur: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !three_s1 |-> slot_s1 == SLOT_CUR)
		else $error("single-corner item not on its current corner");

	a_fan_starts_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && three_cur |=> slot_s1 == SLOT_FAN && valid_s1)
		else $error("triangle item does not start on the fan vertex");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ends |=> corner_q == 2'd0)
		else $error("closing vertex left the corner count set");

	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> stream_q == $past(pos_cur) + POS_BITS'(1))
		else $error("stream position did not advance by one");

	a_no_early_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !last |=> out_valid)
		else $error("held item dropped before its last corner");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the polygon fan triangulator
// Feeds polygon index streams, predicts every emitted triangle corner and
// compares the result port field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
// Stimulus starts with a short directed table: extreme indices, closing
// indices, short polygons, full fans and start_of_mesh inside a polygon.
// Rows with an obvious single-corner answer carry it typed in. All other rows,
// and the random polygons after them, are checked against the fan predictor
// below. One long receiver hold-off fills the block and stalls its input.
module tb_top;
	import pft_pkg::*;

	localparam int unsigned IDX_W        = 24;
	localparam int          TOTAL_ITEMS  = 380;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 400000;

	// one emitted triangle corner
	typedef struct packed {
		logic [IDX_W-1:0]    vtx;
		logic [POS_BITS-1:0] pos;
		logic                last;
	} corner_t;

	// one row of the directed table; vtx/pos are valid only when typed is set
	typedef struct packed {
		logic [IDX_W:0]      raw;
		logic                start;
		logic                typed;
		logic [IDX_W-1:0]    vtx;
		logic [POS_BITS-1:0] pos;
	} dir_row_t;

	localparam int N_ROWS = 24;

	// closing indices are the complement of the vertex: 1FFFFFF ends on 0, 1000000 on FFFFFF
	dir_row_t dir_rows [N_ROWS] = '{
		'{25'h0000000, 1'b1, 1'b1, 24'h000000, 24'd0},  // first item after reset
		'{25'h0FFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 24'd1},  // largest open index
		'{25'h1000000, 1'b0, 1'b1, 24'hFFFFFF, 24'd2},  // most negative closes a triangle
		'{25'h0000005, 1'b0, 1'b1, 24'h000005, 24'd3},
		'{25'h1FFFFFF, 1'b0, 1'b1, 24'h000000, 24'd4},  // two-vertex polygon
		'{25'h1FFFFF8, 1'b0, 1'b1, 24'h000007, 24'd5},  // single-vertex polygon
		'{25'h000000A, 1'b0, 1'b1, 24'h00000A, 24'd6},
		'{25'h000000B, 1'b0, 1'b1, 24'h00000B, 24'd7},
		'{25'h000000C, 1'b0, 1'b1, 24'h00000C, 24'd8},
		'{25'h000000D, 1'b0, 1'b0, 24'h0,      24'd0},  // fan begins
		'{25'h000000E, 1'b0, 1'b0, 24'h0,      24'd0},
		'{25'h1FFFFF0, 1'b0, 1'b0, 24'h0,      24'd0},  // fan closes on 15
		'{25'h0000064, 1'b1, 1'b1, 24'h000064, 24'd0},  // new mesh
		'{25'h00000C8, 1'b0, 1'b1, 24'h0000C8, 24'd1},
		'{25'h000012C, 1'b0, 1'b1, 24'h00012C, 24'd2},
		'{25'h0000190, 1'b1, 1'b1, 24'h000190, 24'd0},  // new mesh inside an open polygon
		'{25'h00001F4, 1'b0, 1'b1, 24'h0001F4, 24'd1},
		'{25'h0000258, 1'b0, 1'b1, 24'h000258, 24'd2},
		'{25'h0FFFFFF, 1'b0, 1'b0, 24'h0,      24'd0},
		'{25'h1000000, 1'b0, 1'b0, 24'h0,      24'd0},
		'{25'h0AAAAAA, 1'b0, 1'b1, 24'hAAAAAA, 24'd5},
		'{25'h0555555, 1'b0, 1'b1, 24'h555555, 24'd6},
		'{25'h1555555, 1'b0, 1'b1, 24'hAAAAAA, 24'd7},  // closes a triangle
		'{25'h1FFFFFF, 1'b1, 1'b1, 24'h000000, 24'd0}   // closing index with new mesh
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [IDX_W:0]      raw_index;
	logic                       start_of_mesh;
	logic                       out_valid;
	logic                       out_ready;
	logic [IDX_W-1:0]           vertex_index;
	logic [POS_BITS-1:0]        source_position;
	logic                       last;

	// fan tracking state of the predictor
	logic [1:0]                 poly_corners = '0;
	logic [IDX_W-1:0]           fan_vtx      = '0;
	logic [POS_BITS-1:0]        fan_pos      = '0;
	logic [IDX_W-1:0]           prev_vtx     = '0;
	logic [POS_BITS-1:0]        prev_pos     = '0;
	logic [POS_BITS-1:0]        next_pos     = '0;

	corner_t                    corner_q [$];
	int                         items_sent   = 0;
	int                         errors       = 0;
	int                         cycle_count  = 0;
	bit                         hold_off     = 1'b0;

	polygon_fan_triangulator #(
		.INDEX_BITS(IDX_W)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_index      (raw_index),
		.start_of_mesh  (start_of_mesh),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.vertex_index   (vertex_index),
		.source_position(source_position),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		errors++;
	endtask

	// Append one expected corner behind the ones still in flight
	task automatic queue_corner(input corner_t c);
		corner_q = {corner_q, c};
	endtask

	// Fan predictor: decode the index, then emit either one pass-through corner
	// or a full triangle (fan vertex, previous vertex, current vertex).
	task automatic triangulate_item(input logic [IDX_W:0] raw, input logic start,
			output corner_t res [3], output int n);
		logic                closes;
		logic [IDX_W-1:0]    vtx;
		logic [POS_BITS-1:0] pos;
		closes = raw[IDX_W];
		vtx    = closes ? ~raw[IDX_W-1:0] : raw[IDX_W-1:0];
		if (start) begin
			next_pos     = '0;
			poly_corners = '0;
		end
		pos = next_pos;
		if (poly_corners <= FAN_CORNERS) begin
			// first three vertices of a polygon pass straight through
			if (poly_corners == '0) begin
				fan_vtx = vtx;
				fan_pos = pos;
			end
			res[0] = '{vtx, pos, 1'b1};
			n = 1;
		end else begin
			res[0] = '{fan_vtx, fan_pos, 1'b0};
			res[1] = '{prev_vtx, prev_pos, 1'b0};
			res[2] = '{vtx, pos, 1'b1};
			n = 3;
		end
		prev_vtx = vtx;
		prev_pos = pos;
		if (closes)
			poly_corners = '0;
		else if (poly_corners < CORNER_MAX)
			poly_corners++;
		// wraps at 2^POS_BITS by width
		next_pos = pos + POS_BITS'(1);
	endtask

	// Sender gap: mostly back to back, now and then a long pause; every fifth
	// block of ten items runs with no gaps at all.
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((items_sent / 10) % 5 == 4)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Offer one input transaction at the falling edge, hold it until accepted,
	// then predict and optionally idle. Entered and left just after a falling edge.
	task automatic send(input logic [IDX_W:0] raw, input logic start, input logic typed,
			input logic [IDX_W-1:0] t_vtx, input logic [POS_BITS-1:0] t_pos, input int gap);
		corner_t res [3];
		int      n;
		in_valid      <= 1'b1;
		raw_index     <= raw;
		start_of_mesh <= start;
		do
			@(posedge clk);
		while (!in_ready);
		triangulate_item(raw, start, res, n);
		items_sent++;
		if (typed)
			queue_corner('{t_vtx, t_pos, 1'b1});
		else
			for (int i = 0; i < n; i++)
				queue_corner(res[i]);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Mix of tiny indices, full-width indices and the two extremes
	function automatic logic [IDX_W-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return IDX_W'($urandom_range(0, 63));
		if (r < 8)
			return IDX_W'($urandom);
		if (r == 8)
			return '1;
		return '0;
	endfunction

	// One well-formed polygon with random size and content; the last vertex closes it
	task automatic feed_polygon();
		int               len;
		int               r;
		logic             st;
		logic [IDX_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = 1;
		else if (r < 20)
			len = 2;
		else if (r < 35)
			len = 3;
		else
			len = $urandom_range(4, 9);
		st = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < len; k++) begin
			v = pick_vertex();
			send((k == len - 1) ? {1'b1, ~v} : {1'b0, v}, (k == 0) ? st : 1'b0,
				1'b0, '0, '0, next_gap());
		end
	endtask

	// Noise: any index, any start bit
	task automatic feed_noise();
		logic [31:0] w;
		w = $urandom;
		send(w[IDX_W:0], w[31], 1'b0, '0, '0, next_gap());
	endtask

	// Receiver side: drive out_ready at the falling edge. Short and long stalls,
	// a recurring steady window, and the forced hold-off.
	initial begin : drain
		int stall;
		int r;
		int cyc;
		stall     = 0;
		cyc       = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ((cyc / 64) % 4 == 3) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					if (r < 92)
						stall = $urandom_range(0, 2);
					else if (r < 98)
						stall = $urandom_range(3, 9);
					else
						stall = $urandom_range(10, 40);
				end
			end
		end
	end

	// Back-pressure: block the result port for a long stretch while the sender
	// keeps offering, so the holding stage fills and in_ready drops.
	initial begin : hold_process
		wait (items_sent >= 120);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Compare each accepted result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		corner_t want;
		if (arst_n && out_valid && out_ready) begin
			if (corner_q.size() == 0) begin
				report("unexpected result", 32'h0, {8'h0, vertex_index});
			end else begin
				want = corner_q.pop_front();
				if (vertex_index !== want.vtx)
					report("vertex_index", 32'(want.vtx), 32'(vertex_index));
				if (source_position !== want.pos)
					report("source_position", 32'(want.pos), 32'(source_position));
				if (last !== want.last)
					report("last", 32'(want.last), 32'(last));
			end
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		raw_index     = '0;
		start_of_mesh = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_ROWS; i++)
			send(dir_rows[i].raw, dir_rows[i].start, dir_rows[i].typed,
				dir_rows[i].vtx, dir_rows[i].pos, next_gap());

		// random polygons with a sprinkle of noise
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				feed_noise();
			else
				feed_polygon();
		end
		in_valid <= 1'b0;

		// let every expected corner arrive, then watch for strays
		while (corner_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
